/* hw/rtl/sdec_pkg.sv */
// ----------------------------------------------------------------------------
// Signed decimal converter package
// Shared types and constants for the signed integer to decimal ASCII unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdec_pkg;

    // Width of the binary input value.
    localparam int unsigned ValueWidth = 32;

    // Number of BCD digits needed for a 32-bit magnitude.
    localparam int unsigned DigitCount = 10;

    // Width of one output character code.
    localparam int unsigned CharWidth = 6;

    // Width of the bit counter used during conversion.
    localparam int unsigned BitCntWidth = $clog2(ValueWidth);

    // Width of the digit counter, wide enough to hold the digit count itself.
    localparam int unsigned DigCntWidth = $clog2(DigitCount + 1);

    typedef logic [3:0]                  t_digit;
    typedef logic [DigitCount*4-1:0]     t_bcd;
    typedef logic [CharWidth-1:0]        t_char;
    typedef logic [ValueWidth-1:0]       t_value;

    // ASCII codes, which fit in the character width.
    localparam t_char CharZero  = 6'd48;
    localparam t_char CharMinus = 6'd45;

endpackage

`default_nettype wire

/* hw/rtl/sdec_in_if.sv */
// ----------------------------------------------------------------------------
// Signed decimal converter input channel
// Valid/ready channel that carries one signed integer per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sdec_in_if;

    logic                 valid;
    logic                 ready;
    logic signed [31:0]   value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);

endinterface

`default_nettype wire

/* hw/rtl/sdec_out_if.sv */
// ----------------------------------------------------------------------------
// Signed decimal converter output channel
// Valid/ready channel that carries one ASCII character per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sdec_out_if;

    logic         valid;
    logic         ready;
    logic [5:0]   character;
    logic         last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);

endinterface

`default_nettype wire

/* hw/rtl/signed_int_to_decimal_ascii_unit.sv */
// Sequence: a 32-step bit-serial shift-and-adjust loop converts the accepted
//   magnitude from binary to BCD; then a minus sign is sent for a negative
//   value, leading zero digits are skipped (up to 9, keeping at least one),
//   and the digits are emitted, most significant first. Output stalls hold
//   the sign and digit emission; a new number is taken only in idle state.
// Reset: synchronous, active low; clears the state machine and output valid.
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII unit
// Converts a signed 32-bit integer into its decimal text, one ASCII character
// per output transaction, with the final character flagged by last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sdec_in_if.sink     i_in,
    sdec_out_if.source  o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_SKIP,
        S_EMIT
    } t_state;

    t_state                                 r_state,    n_state;
    sdec_pkg::t_value                       r_mag,      n_mag;
    sdec_pkg::t_bcd                         r_bcd,      n_bcd;
    logic                                   r_neg,      n_neg;
    logic [sdec_pkg::BitCntWidth-1:0]       r_bit_cnt,  n_bit_cnt;
    logic [sdec_pkg::DigCntWidth-1:0]       r_dig_cnt,  n_dig_cnt;
    logic                                   r_out_valid, n_out_valid;
    sdec_pkg::t_char                        r_out_char, n_out_char;
    logic                                   r_out_last, n_out_last;

    logic                                   w_out_free;
    sdec_pkg::t_bcd                         w_bcd_adj;
    sdec_pkg::t_digit                       w_top_digit;

    // The output register can take a new character when empty or draining.
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_top_digit = r_bcd[sdec_pkg::DigitCount*4-1 -: 4];

    // Add three to every BCD digit of five or more before the next shift.
    always_comb begin
        for (int d = 0; d < sdec_pkg::DigitCount; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                w_bcd_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                w_bcd_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    // Next-state logic for the conversion and emission sequence.
    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_bcd       = r_bcd;
        n_neg       = r_neg;
        n_bit_cnt   = r_bit_cnt;
        n_dig_cnt   = r_dig_cnt;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_neg     = i_in.value[sdec_pkg::ValueWidth-1];
                    n_mag     = i_in.value[sdec_pkg::ValueWidth-1]
                              ? sdec_pkg::t_value'(-i_in.value)
                              : sdec_pkg::t_value'(i_in.value);
                    n_bcd     = '0;
                    n_bit_cnt = '0;
                    n_state   = S_CONV;
                end
            end

            S_CONV: begin
                n_bcd     = {w_bcd_adj[sdec_pkg::DigitCount*4-2:0],
                             r_mag[sdec_pkg::ValueWidth-1]};
                n_mag     = {r_mag[sdec_pkg::ValueWidth-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt + 1'b1;
                if (r_bit_cnt == sdec_pkg::BitCntWidth'(sdec_pkg::ValueWidth - 1)) begin
                    n_dig_cnt = sdec_pkg::DigCntWidth'(sdec_pkg::DigitCount);
                    n_state   = r_neg ? S_SIGN : S_SKIP;
                end
            end

            S_SIGN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = sdec_pkg::CharMinus;
                    n_out_last  = 1'b0;
                    n_state     = S_SKIP;
                end
            end

            // Drop leading zero digits, keeping at least one digit.
            S_SKIP: begin
                if (w_top_digit == 4'd0 && r_dig_cnt != sdec_pkg::DigCntWidth'(1)) begin
                    n_bcd     = {r_bcd[sdec_pkg::DigitCount*4-5:0], 4'd0};
                    n_dig_cnt = r_dig_cnt - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end

            // Emit one digit per cycle while the output register is free, most significant first.
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = sdec_pkg::CharZero + sdec_pkg::t_char'(w_top_digit);
                    n_out_last  = (r_dig_cnt == sdec_pkg::DigCntWidth'(1));
                    n_bcd       = {r_bcd[sdec_pkg::DigitCount*4-5:0], 4'd0};
                    n_dig_cnt   = r_dig_cnt - 1'b1;
                    if (r_dig_cnt == sdec_pkg::DigCntWidth'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs; only control state is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_mag      <= n_mag;
        r_bcd      <= n_bcd;
        r_neg      <= n_neg;
        r_bit_cnt  <= n_bit_cnt;
        r_dig_cnt  <= n_dig_cnt;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // Channel outputs.
    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_out_char;
    assign o_out.last      = r_out_last;

    // An accepted transaction always starts a conversion.
    a_accept_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_CONV))
        else $error("accepted value did not start conversion");

    // The minus sign is never the final character.
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_char != sdec_pkg::CharMinus))
        else $error("minus sign flagged as last character");

    // Digits remain to be sent whenever the skip or emit state is active.
    a_emit_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT || r_state == S_SKIP) |-> (r_dig_cnt != '0))
        else $error("digit counter empty while emitting");

    // After conversion the leading BCD digit is a valid decimal digit.
    a_bcd_digit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT || r_state == S_SKIP) |-> (w_top_digit <= 4'd9))
        else $error("BCD digit out of range");

endmodule

`default_nettype wire

/* test/tb_signed_int_to_decimal_ascii_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the signed integer to decimal ASCII unit
// Drives signed 32-bit integers into the unit and checks every ASCII
// character that comes out, and its last flag, against the text that a
// behavioral predictor works out for each accepted input transaction.
// Hand-picked edge values come first, then random values in several phases
// of sender idling and receiver stalling, including one long receiver
// hold-off that backs the unit up.
// ----------------------------------------------------------------------------

module tb_signed_int_to_decimal_ascii_unit;

    // One character of decimal text as the output channel carries it.
    typedef struct packed {
        sdec_pkg::t_char character;
        logic            last;
    } t_text_char;

    // Holds the decimal text still owed by the unit and checks what arrives.
    class sdec_text_scoreboard;
        t_text_char text_q[$];
        int         mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Expands an accepted value into its expected characters.
        function void note_value(sdec_pkg::t_value value);
            logic             negative;
            sdec_pkg::t_value magnitude;
            sdec_pkg::t_digit digits[sdec_pkg::DigitCount];
            int               ndig;
            t_text_char       item;

            negative  = value[sdec_pkg::ValueWidth-1];
            magnitude = negative ? sdec_pkg::t_value'(-value) : value;
            ndig      = 0;
            // The most negative value keeps its magnitude as an unsigned 2^31.
            do begin
                digits[ndig] = sdec_pkg::t_digit'(magnitude % 10);
                ndig++;
                magnitude = magnitude / 10;
            end while (magnitude != 0 && ndig < sdec_pkg::DigitCount);

            if (negative) begin
                item.character = sdec_pkg::CharMinus;
                item.last      = 1'b0;
                text_q.push_back(item);
            end
            for (int i = ndig - 1; i >= 0; i--) begin
                item.character = sdec_pkg::t_char'(sdec_pkg::CharZero + digits[i]);
                item.last      = (i == 0);
                text_q.push_back(item);
            end
        endfunction

        // Compares one received character with the oldest expected one.
        function void check_char(sdec_pkg::t_char character, logic last);
            t_text_char want;

            if (text_q.size() == 0) begin
                $error("unexpected character %0d (last %0b) with nothing pending",
                       character, last);
                mismatches++;
                return;
            end
            want = text_q.pop_front();
            if (character !== want.character) begin
                $error("character: expected %0d, got %0d", want.character, character);
                mismatches++;
            end
            if (last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, last);
                mismatches++;
            end
        endfunction

        function int pending();
            return text_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sdec_in_if  in_ch ();
    sdec_out_if out_ch ();

    signed_int_to_decimal_ascii_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sdec_text_scoreboard text_sb;

    // Idle and stall rates of the current phase, in percent.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // Cycles the receiver still holds ready low for the back-pressure phase.
    int unsigned hold_cycles;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog for a hung or lost transaction.
    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    // Receiver: checks each output transaction and randomizes ready.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                text_sb.check_char(out_ch.character, out_ch.last);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offers one value and returns once the unit has taken it.
    task automatic send_value(input sdec_pkg::t_value value);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            in_ch.value <= $urandom();
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= value;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        text_sb.note_value(value);
    endtask

    // Random value, biased toward every text length and the edge values.
    function automatic sdec_pkg::t_value pick_value();
        int unsigned      span;
        int unsigned      ndig;
        sdec_pkg::t_value magnitude;

        span = 1;
        case ($urandom_range(3))
            0: begin
                return $urandom();
            end
            1: begin
                // Magnitude with a random number of digits.
                ndig = $urandom_range(1, 9);
                for (int i = 0; i < ndig; i++) span = span * 10;
                magnitude = $urandom() % span;
                return $urandom_range(1) ? sdec_pkg::t_value'(-magnitude) : magnitude;
            end
            2: begin
                // Powers of ten and their neighbors, where the length changes.
                ndig = $urandom_range(0, 9);
                for (int i = 0; i < ndig; i++) span = span * 10;
                magnitude = span - $urandom_range(1);
                return $urandom_range(1) ? sdec_pkg::t_value'(-magnitude) : magnitude;
            end
            default: begin
                case ($urandom_range(4))
                    0:       return 32'h0000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h8000_0000;
                    3:       return 32'h8000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    // Runs a number of random values under the given idle and stall rates.
    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                             input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_value(pick_value());
    endtask

    // Main sequence.
    initial begin
        sdec_pkg::t_value edge_values[$];

        text_sb        = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Edge values: zero, single digits, length steps, both extremes.
        edge_values = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd9, -32'sd10,
                        32'd99, 32'd100, -32'sd123, 32'd999999999, 32'd1000000000,
                        -32'sd1000000000, 32'd1234567890, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
                        32'd4000000000};
        foreach (edge_values[i]) send_value(edge_values[i]);

        run_phase(0, 0, 60);
        run_phase(82, 0, 50);
        run_phase(0, 82, 50);
        run_phase(18, 18, 60);

        // Long receiver hold-off while the sender keeps offering values.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 400;
        repeat (10) send_value(pick_value());

        run_phase(0, 0, 20);
        in_ch.valid <= 1'b0;

        while (text_sb.pending() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (text_sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/sdec_pkg.sv
hw/rtl/sdec_in_if.sv
hw/rtl/sdec_out_if.sv
hw/rtl/signed_int_to_decimal_ascii_unit.sv
test/tb_signed_int_to_decimal_ascii_unit.sv
